// ===== hdl/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Stream field widths (fixed by the interface)
  localparam int KIND_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int RROW_W      = 5;
  localparam int RCOL_W      = 7;
  localparam int CELL_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Input word kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Operation codes between front and back
  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_NL    = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_NOP   = 3'd4;

  // Character codes
  localparam logic [7:0] SPACE_CH    = 8'h20;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;
  localparam logic [7:0] NL_CH       = 8'h0A;
  localparam logic [7:0] BSLASH_CH   = 8'h5C;
  localparam logic [7:0] X_CH        = 8'h78;
  localparam logic [7:0] RESET_COLOR = 8'h06;

  typedef struct packed {
    logic [2:0]        code;
    logic [7:0]        ch;
    logic [RROW_W-1:0] row;
    logic [RCOL_W-1:0] col;
    logic              first;  // first op of an input word
    logic              last;   // last op of an input word: produces the result
  } tcw_op_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_ram.sv =====
// ---------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tcw_front.sv =====
// ---------------------------------------------------------------------------
// tcw_front
// Accepts input words, classifies them and expands escaped bytes into ops.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            init_done,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [tcw_pkg::KIND_W-1:0]      in_tuser,
  output logic                                 op_valid,
  input  wire logic                            op_ready,
  output tcw_pkg::tcw_op_t                     op
);

  import tcw_pkg::*;

  localparam logic [7:0] DIGIT0_CH  = 8'h30;
  localparam logic [7:0] ALPHA_BASE = 8'h57;  // 'a' - 10

  function automatic logic [7:0] hex_ch(input logic [3:0] n);
    if (n < 4'd10) begin
      hex_ch = DIGIT0_CH + {4'd0, n};
    end else begin
      hex_ch = ALPHA_BASE + {4'd0, n};
    end
  endfunction

  logic [BYTE_W-1:0] byte_in;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_column;
  logic              esc_act_r, esc_act_nxt;
  logic [1:0]        esc_step_r, esc_step_nxt;
  logic [7:0]        esc_byte_r, esc_byte_nxt;
  logic              accept;
  logic              is_esc;
  tcw_op_t           cls;

  assign byte_in     = in_tdata[7:0];
  assign read_row    = in_tdata[12:8];
  assign read_column = in_tdata[19:13];

  // classify the incoming word
  always_comb begin
    cls.code  = OP_NOP;
    cls.ch    = byte_in;
    cls.row   = read_row;
    cls.col   = read_column;
    cls.first = 1'b1;
    cls.last  = 1'b1;
    is_esc    = 1'b0;
    case (in_tuser)
      KIND_PUT: begin
        if (byte_in == NL_CH) begin
          cls.code = OP_NL;
        end else if (byte_in >= PRINT_LO && byte_in <= PRINT_HI) begin
          cls.code = OP_PUT;
        end else begin
          cls.code = OP_PUT;
          cls.ch   = BSLASH_CH;
          cls.last = 1'b0;
          is_esc   = 1'b1;
        end
      end
      KIND_CLEAR: cls.code = OP_CLEAR;
      KIND_READ: begin
        if (32'(read_row) < ROWS && 32'(read_column) < COLUMNS) begin
          cls.code = OP_READ;
        end
      end
      default: cls.code = OP_NOP;
    endcase
  end

  assign in_tready = !esc_act_r && init_done && op_ready;
  assign accept    = in_tvalid && in_tready;
  assign op_valid  = esc_act_r || (in_tvalid && init_done);

  // escape tail: 'x', high digit, low digit
  always_comb begin
    op = cls;
    if (esc_act_r) begin
      op.code  = OP_PUT;
      op.first = 1'b0;
      op.last  = (esc_step_r == 2'd3);
      case (esc_step_r)
        2'd1:    op.ch = X_CH;
        2'd2:    op.ch = hex_ch(esc_byte_r[7:4]);
        2'd3:    op.ch = hex_ch(esc_byte_r[3:0]);
        default: op.ch = BSLASH_CH;
      endcase
    end
  end

  always_comb begin
    esc_act_nxt  = esc_act_r;
    esc_step_nxt = esc_step_r;
    esc_byte_nxt = esc_byte_r;
    if (esc_act_r) begin
      if (op_ready) begin
        esc_step_nxt = esc_step_r + 2'd1;
        if (esc_step_r == 2'd3) begin
          esc_act_nxt = 1'b0;
        end
      end
    end else if (accept && is_esc) begin
      esc_act_nxt  = 1'b1;
      esc_step_nxt = 2'd1;
      esc_byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_act_r  <= 1'b0;
      esc_step_r <= 2'd0;
    end else begin
      esc_act_r  <= esc_act_nxt;
      esc_step_r <= esc_step_nxt;
    end
    esc_byte_r <= esc_byte_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/tcw_opq.sv =====
// ---------------------------------------------------------------------------
// tcw_opq
// Two-entry op queue between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_opq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire tcw_pkg::tcw_op_t  wr_op,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output tcw_pkg::tcw_op_t       rd_op
);

  import tcw_pkg::*;

  localparam int QD = 2;
  localparam int PW = $clog2(QD);
  localparam int NW = $clog2(QD + 1);

  tcw_op_t         q_r [QD];
  logic [PW-1:0]   wp_r, rp_r;
  logic [NW-1:0]   cnt_r;
  logic            push, pop;

  assign wr_ready = (cnt_r != NW'(QD));
  assign rd_valid = (cnt_r != '0);
  assign rd_op    = q_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QD - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QD - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
    if (push) begin
      q_r[wp_r] <= wr_op;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcw_back.sv =====
// ---------------------------------------------------------------------------
// tcw_back
// Executes ops on the screen store: puts, newlines, scroll, clear, read.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int SCROLL_LINES = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            op_valid,
  output logic                                 op_ready,
  input  wire tcw_pkg::tcw_op_t                op,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 init_done
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int AW1        = $clog2(CELL_COUNT + 1);
  localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW         = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LINES_C    = (SCROLL_LINES > ROWS) ? ROWS : SCROLL_LINES;
  localparam int OFF        = LINES_C * COLUMNS;
  localparam int COPY_N     = (ROWS - LINES_C) * COLUMNS;
  localparam int ROW_AFTER  = ROWS - LINES_C;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;
  localparam logic [1:0] ST_FILL = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              scr_r, scr_nxt, scr_eff;
  logic              opl_r, opl_nxt;
  logic              init_r, init_nxt;
  logic [AW1-1:0]    sw_r, sw_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic              pv_r, pv_nxt;
  logic [7:0]        color_r;
  logic [7:0]        fill_color;
  logic              out_vld_r;
  logic [CELL_W-1:0] ocell_r;
  logic [RROW_W-1:0] orow_r;
  logic [RCOL_W-1:0] ocol_r;
  logic              oscr_r;
  logic              out_free, pop, fin, do_nl, issue;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic [AW-1:0]     put_a, rd_a;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg_ready  = 1'b1;
  assign init_done  = !init_r;
  assign out_free   = !out_vld_r || out_tready;
  assign op_ready   = (st_r == ST_IDLE) && (!op.last || out_free);
  assign pop        = op_valid && op_ready;
  assign col_inc    = {1'b0, col_r} + (CW+1)'(1);
  assign row_inc    = {1'b0, row_r} + (RW+1)'(1);
  assign put_a      = AW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign rd_a       = AW'(32'(op.row) * COLUMNS + 32'(op.col));
  assign issue      = (sw_r != AW1'(CELL_COUNT));
  assign fill_color = init_r ? RESET_COLOR : color_r;
  assign raddr      = (st_r == ST_COPY) ? sw_r[AW-1:0] : rd_a;

  always_comb begin
    st_nxt   = st_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    scr_nxt  = scr_r;
    opl_nxt  = opl_r;
    init_nxt = init_r;
    sw_nxt   = sw_r;
    wa_nxt   = wa_r;
    pv_nxt   = 1'b0;
    we       = 1'b0;
    waddr    = sw_r[AW-1:0];
    wdata    = {fill_color, SPACE_CH};
    fin      = 1'b0;
    do_nl    = 1'b0;
    scr_eff  = op.first ? 1'b0 : scr_r;
    case (st_r)
      ST_IDLE: begin
        if (pop) begin
          scr_nxt = scr_eff;
          opl_nxt = op.last;
          case (op.code)
            OP_PUT: begin
              we    = 1'b1;
              waddr = put_a;
              wdata = {color_r, op.ch};
              if (col_inc == (CW+1)'(COLUMNS)) begin
                do_nl = 1'b1;
              end else begin
                col_nxt = col_inc[CW-1:0];
              end
            end
            OP_NL: do_nl = 1'b1;
            OP_CLEAR: begin
              st_nxt = ST_FILL;
              sw_nxt = '0;
            end
            OP_READ: st_nxt = ST_RD;
            default: ;
          endcase
          if (do_nl) begin
            col_nxt = '0;
            if (row_inc >= (RW+1)'(ROWS)) begin
              // bottom reached: scroll, then blank the freed rows
              row_nxt = RW'(ROW_AFTER);
              scr_nxt = 1'b1;
              if (COPY_N > 0) begin
                st_nxt = ST_COPY;
                sw_nxt = AW1'(OFF);
                wa_nxt = '0;
              end else begin
                st_nxt = ST_FILL;
                sw_nxt = '0;
              end
            end else begin
              row_nxt = row_inc[RW-1:0];
            end
          end
          fin = op.last && (st_nxt == ST_IDLE);
        end
      end
      ST_RD: begin
        st_nxt = ST_IDLE;
        fin    = opl_r;
      end
      ST_COPY: begin
        // reads run one cell ahead of writes; writes always trail reads
        if (issue) begin
          sw_nxt = sw_r + AW1'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          we     = 1'b1;
          waddr  = wa_r;
          wdata  = rdata;
          wa_nxt = wa_r + AW'(1);
          if (!issue) begin
            st_nxt = ST_FILL;
            sw_nxt = AW1'(COPY_N);
          end
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (sw_r == AW1'(CELL_COUNT - 1)) begin
          st_nxt   = ST_IDLE;
          init_nxt = 1'b0;
          fin      = opl_r;
        end else begin
          sw_nxt = sw_r + AW1'(1);
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_FILL;
      row_r     <= '0;
      col_r     <= '0;
      scr_r     <= 1'b0;
      opl_r     <= 1'b0;
      init_r    <= 1'b1;
      sw_r      <= '0;
      pv_r      <= 1'b0;
      color_r   <= RESET_COLOR;
      out_vld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      scr_r  <= scr_nxt;
      opl_r  <= opl_nxt;
      init_r <= init_nxt;
      sw_r   <= sw_nxt;
      pv_r   <= pv_nxt;
      if (cfg_valid) begin
        color_r <= cfg_data;
      end
      if (fin) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    wa_r <= wa_nxt;
    if (fin) begin
      ocell_r <= (st_r == ST_RD) ? rdata : '0;
      orow_r  <= RROW_W'(row_nxt);
      ocol_r  <= RCOL_W'(col_nxt);
      oscr_r  <= scr_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, oscr_r, ocol_r, orow_r, ocell_r};

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < COLUMNS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) < ROWS)
    else $error("cursor row out of range");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COPY && pv_r) |-> ({1'b0, wa_r} < {1'b0, sw_r}))
    else $error("scroll copy write overtook read");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD) |=> out_vld_r)
    else $error("read op produced no result word");

endmodule

`default_nettype wire

// ===== hdl/text_console_character_writer_top.sv =====
// ---------------------------------------------------------------------------
// text_console_character_writer_top
// Text console writer: screen store, cursor, escapes, scroll, clear and read.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one word per console command. tuser = kind (put, clear, read).
//   out_* : exactly one result word per input word, in order.
//   cfg_* : writes the text color; always ready.
// Throughput:
//   Printable byte, newline without scroll, unused kind: one word per cycle
//   sustained while the output register can hand each result on.
//   Read: one extra ST_RD state for the registered RAM read.
//   Escaped byte: four character puts; the front takes no new word until the last.
//   Clear: sweeps ROWS*COLUMNS cells (2000 at 80x25), one cell store per cycle.
//   Scroll: copy up, then blank the bottom rows, every cell written once,
//   bounded by the single write port of the screen RAM.
// Reset:
//   Cursor to 0,0, color 6. The screen is then swept to spaces in color 6,
//   and in_tready stays low until the sweep ends.
// Stalls:
//   A finished result waits in the output register; the front keeps taking
//   words into a two-entry op queue until it fills.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_character_writer_top #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int SCROLL_LINES = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input: tdata = byte_in[7:0], read_row[12:8], read_column[19:13], zero pad
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser = kind[1:0]
  input  wire logic [tcw_pkg::KIND_W-1:0]      in_tuser,
  // result: tdata = cell_value[15:0], cursor_row[20:16],
  //         cursor_column[27:21], scrolled[28], zero pad
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // text color register write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [7:0]                      cfg_data
);

  import tcw_pkg::*;

  tcw_op_t fe_op, be_op;
  logic    fe_valid, fe_ready;
  logic    be_valid, be_ready;
  logic    init_done;

  // front: classify words, expand escapes into four puts
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .op_valid  (fe_valid),
    .op_ready  (fe_ready),
    .op        (fe_op)
  );

  // decouples front from long scroll and clear sweeps
  tcw_opq u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_op    (fe_op),
    .rd_valid (be_valid),
    .rd_ready (be_ready),
    .rd_op    (be_op)
  );

  // back: screen RAM, cursor, sweeps, result register
  tcw_back #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .SCROLL_LINES (SCROLL_LINES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .op_valid   (be_valid),
    .op_ready   (be_ready),
    .op         (be_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .init_done  (init_done)
  );

endmodule

`default_nettype wire

// ===== tb/tb_text_console_character_writer_top.sv =====
// ---------------------------------------------------------------------------
// tb_text_console_character_writer_top
// Self-checking bench for the text console character writer.
// A shadow screen, cursor and color track every accepted word and predict
// the status word it returns. Directed words hit the byte classes, escapes,
// reads in and out of range, clear and the unused kind. Then three random
// phases run at different text colors and idle patterns.
// ---------------------------------------------------------------------------

module tb_text_console_character_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // Geometry used for this build of the block
  localparam int COLS       = 80;
  localparam int ROWS_N     = 25;
  localparam int SCROLL_N   = 3;
  localparam int CELLS      = COLS * ROWS_N;

  // Unused input kind: block must leave everything alone
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;  // '0'
  localparam logic [7:0] LETTER_A   = 8'h61;  // 'a'

  // Watchdog: cycles with no handshake at all. The slowest step is a scroll,
  // and the post-reset sweep is as long.
  localparam int STALL_LIMIT = 20000;
  // Quiet cycles after the last result before a color write or the end
  localparam int SETTLE      = 16;

  localparam int PHASE_WORDS = 560;

  // Status word fields, laid out as in out_tdata (lowest field last here)
  typedef struct packed {
    logic              scrolled;
    logic [RCOL_W-1:0] col;
    logic [RROW_W-1:0] row;
    logic [CELL_W-1:0] cell_value;
  } console_status_t;

  // -------------------------------------------------------------------------
  // DUT signals; every input has a known value from time 0
  // -------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_data   = '0;

  text_console_character_writer_top #(
    .COLUMNS      (COLS),
    .ROWS         (ROWS_N),
    .SCROLL_LINES (SCROLL_N)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Shadow console: screen, cursor, color
  // -------------------------------------------------------------------------
  logic [CELL_W-1:0] shadow_cells [0:CELLS-1];
  int unsigned       shadow_row;
  int unsigned       shadow_col;
  logic [7:0]        shadow_color;
  bit                scroll_happened;

  console_status_t   status_due [$];   // predicted status words, oldest first
  int unsigned       mismatch_count = 0;

  // Idle odds in percent, set per phase
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_color, SPACE_CH};
  endfunction

  function automatic void scroll_screen();
    int unsigned lines;
    lines = (SCROLL_N > ROWS_N) ? ROWS_N : SCROLL_N;
    for (int i = 0; i + lines * COLS < CELLS; i++)
      shadow_cells[i] = shadow_cells[i + lines * COLS];
    for (int i = (ROWS_N - lines) * COLS; i < CELLS; i++)
      shadow_cells[i] = {shadow_color, SPACE_CH};
    shadow_row      = (shadow_row >= lines) ? shadow_row - lines : 0;
    scroll_happened = 1'b1;
  endfunction

  function automatic void line_feed();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS_N) scroll_screen();
  endfunction

  function automatic void store_char(logic [7:0] ch);
    if (shadow_row < ROWS_N && shadow_col < COLS)
      shadow_cells[shadow_row * COLS + shadow_col] = {shadow_color, ch};
    shadow_col++;
    if (shadow_col >= COLS) line_feed();   // last column wraps
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return DIGIT_ZERO + 8'(nib);
    return LETTER_A + 8'(nib) - 8'd10;
  endfunction

  function automatic void console_put(logic [7:0] ch);
    if (ch == NL_CH) begin
      line_feed();
    end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
      store_char(ch);
    end else begin
      // non-printable: shown as \xHH, lowercase
      store_char(BSLASH_CH);
      store_char(X_CH);
      store_char(hex_char(ch[7:4]));
      store_char(hex_char(ch[3:0]));
    end
  endfunction

  // Applies one accepted word to the shadow console, returns its status word
  function automatic console_status_t console_apply(logic [KIND_W-1:0] kind,
                                                    logic [7:0] ch,
                                                    logic [RROW_W-1:0] rr,
                                                    logic [RCOL_W-1:0] rc);
    console_status_t st;
    st              = '0;
    scroll_happened = 1'b0;
    case (kind)
      KIND_PUT:   console_put(ch);
      KIND_CLEAR: blank_screen();
      KIND_READ: begin
        if (rr < ROWS_N && rc < COLS) st.cell_value = shadow_cells[rr * COLS + rc];
      end
      default: ;  // unused kind
    endcase
    st.row      = shadow_row[RROW_W-1:0];
    st.col      = shadow_col[RCOL_W-1:0];
    st.scrolled = scroll_happened;
    return st;
  endfunction

  // -------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] ERROR %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Receiver back-pressure: one decision per cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted status word is compared with the oldest prediction
  always @(posedge clk) begin : check_status
    console_status_t got;
    console_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = console_status_t'(out_tdata[$bits(console_status_t)-1:0]);
      if (status_due.size() == 0) begin
        report_mismatch("status word with nothing outstanding", out_tdata, 0);
      end else begin
        want = status_due.pop_front();
        if (got.cell_value != want.cell_value)
          report_mismatch("cell_value", got.cell_value, want.cell_value);
        if (got.row != want.row)
          report_mismatch("cursor_row", got.row, want.row);
        if (got.col != want.col)
          report_mismatch("cursor_column", got.col, want.col);
        if (got.scrolled != want.scrolled)
          report_mismatch("scrolled", got.scrolled, want.scrolled);
      end
    end
  end

  // Watchdog: ends the run when no channel has moved a word for too long
  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("text_console_character_writer_top: mismatch");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------
  // Sends one word with a random lead-in gap, predicts its status on accept.
  // in_tvalid stays high after the accept so back-to-back words are possible.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [7:0] ch,
                           input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, rc, rr, ch};
    do @(posedge clk); while (!in_tready);
    status_due.push_back(console_apply(kind, ch, rr, rc));
  endtask

  // Holds the sender until every predicted word has come back, then settles
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Color register write, only with the block idle
  task automatic write_color(input logic [7:0] color);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    shadow_color  = color;
  endtask

  // One random word. Mostly text and newlines so the cursor walks the whole
  // screen and scrolls; reads lean toward the rows just written.
  task automatic send_random_word();
    int unsigned       pick;
    int unsigned       back;
    logic [KIND_W-1:0] kind;
    logic [7:0]        ch;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    rr   = RROW_W'($urandom_range(31));
    rc   = RCOL_W'($urandom_range(127));
    kind = KIND_PUT;
    if (pick < 50) begin
      ch = 8'($urandom_range(PRINT_HI, PRINT_LO));
    end else if (pick < 62) begin
      ch = NL_CH;
    end else if (pick < 72) begin
      // escape: control bytes, or DEL and the top half
      ch = $urandom_range(1) ? 8'($urandom_range(8'h1F)) : 8'($urandom_range(255, 8'h7F));
    end else if (pick < 90) begin
      kind = KIND_READ;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          back = $urandom_range(3);
          rr   = RROW_W'((shadow_row >= back) ? shadow_row - back : 0);
          rc   = RCOL_W'($urandom_range(COLS - 1));
        end
        5, 6, 7: begin
          rr = RROW_W'($urandom_range(ROWS_N - 1));
          rc = RCOL_W'($urandom_range(COLS - 1));
        end
        default: ;  // anywhere, out of range too
      endcase
    end else if (pick < 92) begin
      kind = KIND_CLEAR;
    end else if (pick < 95) begin
      kind = KIND_UNUSED;
    end
    // remaining picks: put with a fully random byte
    send_word(kind, ch, rr, rc);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Reset screen, every byte class, escapes, reads at and past the edges,
  // clear and the unused kind, at the reset color.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(KIND_READ, 8'h00, 5'd0, 7'd0);
    send_word(KIND_READ, 8'hFF, 5'd24, 7'd79);
    send_word(KIND_READ, 8'h00, 5'd31, 7'd127);    // both out of range
    send_word(KIND_READ, 8'h00, 5'd25, 7'd0);      // row just past the end
    send_word(KIND_READ, 8'h00, 5'd0, 7'd80);      // column just past the end
    send_word(KIND_PUT, PRINT_LO, 5'd0, 7'd0);
    send_word(KIND_PUT, PRINT_HI, 5'd31, 7'd127);
    send_word(KIND_PUT, 8'h41, 5'd0, 7'd0);
    send_word(KIND_PUT, NL_CH, 5'd0, 7'd0);
    send_word(KIND_PUT, 8'h00, 5'd0, 7'd0);        // \x00
    send_word(KIND_PUT, 8'hFF, 5'd0, 7'd0);        // \xff
    send_word(KIND_PUT, 8'h7F, 5'd0, 7'd0);        // just above printable
    send_word(KIND_PUT, 8'h1F, 5'd0, 7'd0);        // just below printable
    send_word(KIND_PUT, 8'hA9, 5'd0, 7'd0);        // low digit from low nibble
    send_word(KIND_UNUSED, 8'h41, 5'd3, 7'd3);
    send_word(KIND_READ, 8'h00, 5'd0, 7'd2);
    send_word(KIND_READ, 8'h00, 5'd1, 7'd3);
    send_word(KIND_READ, 8'h00, 5'd1, 7'd7);
    send_word(KIND_READ, 8'h00, 5'd1, 7'd19);
    send_word(KIND_CLEAR, 8'h41, 5'd1, 7'd1);      // cursor must stay put
    send_word(KIND_READ, 8'h00, 5'd1, 7'd0);
    send_word(KIND_PUT, 8'h5A, 5'd0, 7'd0);
  endtask

  // One random phase at a given color and idle pattern. Halfway through the
  // sender holds off until everything outstanding has returned.
  task automatic test_random_phase(input logic [7:0] color, input int unsigned words,
                                   input int unsigned send_pct, input int unsigned recv_pct);
    write_color(color);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < words; i++) begin
      if (i == words / 2) wait_drained();
      send_random_word();
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    shadow_color    = RESET_COLOR;
    shadow_row      = 0;
    shadow_col      = 0;
    scroll_happened = 1'b0;
    blank_screen();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phase(8'h00, PHASE_WORDS, 35, 84);
    test_random_phase(8'hFF, PHASE_WORDS, 84, 35);
    test_random_phase(8'($urandom_range(255)), PHASE_WORDS, 0, 0);

    wait_drained();
    if (status_due.size() != 0)
      report_mismatch("status words never returned", status_due.size(), 0);
    if (mismatch_count == 0) begin
      $display("text_console_character_writer_top: match");
    end else begin
      $display("text_console_character_writer_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_front.sv
hdl/tcw_opq.sv
hdl/tcw_back.sv
hdl/text_console_character_writer_top.sv
tb/tb_text_console_character_writer_top.sv
